FILE: src/sdbf_pkg.sv
package sdbf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = KEY_BITS + 128;

  localparam logic [2:0] KIND_UPDATE = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_LOOKUP = 3'd2;
  localparam logic [2:0] KIND_NEXT   = 3'd3;
  localparam logic [2:0] KIND_HOLE   = 3'd4;
  localparam logic [2:0] KIND_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_SCAN, S_HGAP, S_HEND, S_HSTEP, S_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic hole_gap;
    logic hole_end;
    logic hole_next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic is_hole;
    logic scan_busy;
    logic best_found;
    logic hole_stop;
    logic out_busy;
  } sts_t;

endpackage

FILE: src/sdbf_ram.sv
module sdbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/sdbf_ctrl.sv
module sdbf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdbf_pkg::sts_t  sts,
  output sdbf_pkg::cmd_t  cmd
);

  sdbf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdbf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of one request
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      sdbf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sdbf_pkg::S_DECIDE;
        end
      end
      sdbf_pkg::S_DECIDE: begin
        if (sts.need_scan) begin
          cmd.scan_start = 1'b1;
          state_next     = sdbf_pkg::S_SCAN;
        end else begin
          state_next = sdbf_pkg::S_FIN;
        end
      end
      sdbf_pkg::S_SCAN: begin
        if (!sts.scan_busy) begin
          if (sts.is_hole && sts.best_found) begin
            state_next = sdbf_pkg::S_HGAP;
          end else begin
            state_next = sdbf_pkg::S_FIN;
          end
        end
      end
      sdbf_pkg::S_HGAP: begin
        cmd.hole_gap = 1'b1;
        state_next   = sdbf_pkg::S_HEND;
      end
      sdbf_pkg::S_HEND: begin
        cmd.hole_end = 1'b1;
        state_next   = sdbf_pkg::S_HSTEP;
      end
      sdbf_pkg::S_HSTEP: begin
        if (sts.hole_stop) begin
          state_next = sdbf_pkg::S_FIN;
        end else begin
          cmd.hole_next  = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = sdbf_pkg::S_SCAN;
        end
      end
      sdbf_pkg::S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = sdbf_pkg::S_IDLE;
        end
      end
      default: state_next = sdbf_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: src/sdbf_dp.sv
module sdbf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  sdbf_pkg::cmd_t                cmd,
  output sdbf_pkg::sts_t                sts,
  input  logic [2:0]                    in_kind,
  input  logic [sdbf_pkg::KEY_BITS-1:0] in_key,
  input  logic [63:0]                   in_offset,
  input  logic [63:0]                   in_length,
  input  logic [63:0]                   in_min,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [63:0]                   out_offset,
  output logic [63:0]                   out_length
);

  localparam int IW = sdbf_pkg::IDX_W;
  localparam int CW = sdbf_pkg::CNT_W;
  localparam int KW = sdbf_pkg::KEY_BITS;

  // request words
  logic [2:0]  kind;
  logic [KW-1:0] key;
  logic [63:0] seg_off, seg_len, hole_min;

  // table state
  logic [sdbf_pkg::TABLE_DEPTH-1:0] used;
  logic [CW-1:0] alloc;

  // scan pipeline
  logic          scan_on, rd_valid;
  logic [CW-1:0] addr;
  logic [IW-1:0] rd_idx;
  logic [sdbf_pkg::ENTRY_W-1:0] rdata, wdata;
  logic          we;
  logic [IW-1:0] ram_addr;

  // scan results
  logic          hit_found, best_found;
  logic [IW-1:0] hit_idx;
  logic [63:0]   hit_off, hit_len, best_off, best_len;

  // hole walk
  logic [63:0]   search, end_r, hole_off, hole_len;
  logic          hole_found;
  logic [CW-1:0] steps;

  logic [KW-1:0] q_key;
  logic [63:0]   q_off, q_len, gap;
  logic [64:0]   sum;
  logic          q_used, key_eq, hit_cond, best_cond;
  logic          key_zero, room;

  assign q_key  = rdata[sdbf_pkg::ENTRY_W-1 -: KW];
  assign q_off  = rdata[127:64];
  assign q_len  = rdata[63:0];
  assign q_used = used[rd_idx];
  assign key_eq = (q_key == key);
  assign hit_cond = (kind == sdbf_pkg::KIND_UPDATE) ? (!q_used || key_eq) : (q_used && key_eq);
  assign best_cond = q_used && (q_off >= search) && (!best_found || q_off < best_off);
  assign gap = best_off - search;
  assign sum = {1'b0, best_off} + {1'b0, best_len};
  assign key_zero = (key == '0);
  assign room = (alloc < CW'(sdbf_pkg::TABLE_DEPTH));

  // status to controller
  always_comb begin
    sts.is_hole    = (kind == sdbf_pkg::KIND_HOLE);
    sts.scan_busy  = scan_on || rd_valid;
    sts.best_found = best_found;
    sts.hole_stop  = (end_r <= best_off) || (steps == CW'(sdbf_pkg::TABLE_DEPTH - 1));
    sts.out_busy   = out_valid && !out_ready;
    case (kind) inside
      sdbf_pkg::KIND_UPDATE, sdbf_pkg::KIND_DELETE, sdbf_pkg::KIND_LOOKUP:
        sts.need_scan = !key_zero;
      sdbf_pkg::KIND_NEXT, sdbf_pkg::KIND_HOLE:
        sts.need_scan = 1'b1;
      default:
        sts.need_scan = 1'b0;
    endcase
  end

  // table write on finishing an update
  always_comb begin
    we       = 1'b0;
    ram_addr = addr[IW-1:0];
    wdata    = {key, seg_off, seg_len};
    if (cmd.finish && kind == sdbf_pkg::KIND_UPDATE && !key_zero) begin
      if (hit_found) begin
        we       = 1'b1;
        ram_addr = hit_idx;
      end else if (room) begin
        we       = 1'b1;
        ram_addr = alloc[IW-1:0];
      end
    end
  end

  sdbf_ram #(.WIDTH(sdbf_pkg::ENTRY_W), .DEPTH(sdbf_pkg::TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (ram_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // request capture and hole walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind     <= in_kind;
      key      <= in_key;
      seg_off  <= in_offset;
      seg_len  <= in_length;
      hole_min <= in_min;
      search   <= (in_kind == sdbf_pkg::KIND_HOLE) ? 64'd0 : in_offset;
      steps    <= '0;
      hole_found <= 1'b0;
      hole_off <= '0;
      hole_len <= '0;
    end
    if (cmd.hole_gap && gap >= hole_min && (!hole_found || gap < hole_len)) begin
      hole_found <= 1'b1;
      hole_off   <= search;
      hole_len   <= gap;
    end
    if (cmd.hole_end) begin
      end_r <= sum[64] ? '1 : sum[63:0];
    end
    if (cmd.hole_next) begin
      search <= end_r;
      steps  <= steps + 1'b1;
    end
  end

  // scan address sequencing and per-entry compare
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_on  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= scan_on && (addr < alloc);
      if (cmd.scan_start) begin
        scan_on <= 1'b1;
      end else if (scan_on && !(addr + 1'b1 < alloc)) begin
        scan_on <= 1'b0;
      end
    end
    rd_idx <= addr[IW-1:0];
    if (cmd.scan_start) begin
      addr       <= '0;
      hit_found  <= 1'b0;
      best_found <= 1'b0;
    end else begin
      if (scan_on) begin
        addr <= addr + 1'b1;
      end
      if (rd_valid && !hit_found && hit_cond) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_off   <= q_off;
        hit_len   <= q_len;
      end
      if (rd_valid && best_cond) begin
        best_found <= 1'b1;
        best_off   <= q_off;
        best_len   <= q_len;
      end
    end
  end

  // table state and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      alloc     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        case (kind)
          sdbf_pkg::KIND_UPDATE: begin
            if (!key_zero) begin
              if (hit_found) begin
                used[hit_idx] <= 1'b1;
              end else if (room) begin
                used[alloc[IW-1:0]] <= 1'b1;
                alloc <= alloc + 1'b1;
              end
            end
          end
          sdbf_pkg::KIND_DELETE: begin
            if (!key_zero && hit_found) begin
              used[hit_idx] <= 1'b0;
            end
          end
          sdbf_pkg::KIND_CLEAR: begin
            used  <= '0;
            alloc <= '0;
          end
          default: ;
        endcase
      end
    end
    if (cmd.finish) begin
      out_status <= sdbf_pkg::ST_NOTFOUND;
      out_offset <= '0;
      out_length <= '0;
      case (kind)
        sdbf_pkg::KIND_UPDATE: begin
          out_status <= (key_zero || hit_found || room) ? sdbf_pkg::ST_OK : sdbf_pkg::ST_FULL;
        end
        sdbf_pkg::KIND_DELETE: begin
          if (!key_zero && hit_found) out_status <= sdbf_pkg::ST_OK;
        end
        sdbf_pkg::KIND_LOOKUP: begin
          if (!key_zero && hit_found) begin
            out_status <= sdbf_pkg::ST_OK;
            out_offset <= hit_off;
            out_length <= hit_len;
          end
        end
        sdbf_pkg::KIND_NEXT: begin
          if (best_found) begin
            out_status <= sdbf_pkg::ST_OK;
            out_offset <= best_off;
            out_length <= best_len;
          end
        end
        sdbf_pkg::KIND_HOLE: begin
          if (hole_found) begin
            out_status <= sdbf_pkg::ST_OK;
            out_offset <= hole_off;
            out_length <= hole_len;
          end
        end
        sdbf_pkg::KIND_CLEAR: out_status <= sdbf_pkg::ST_OK;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/segment_directory_best_fit_hole_unit.sv
// Clear, ignored key and unused kinds skip the slot scan; lookups, deletes, updates
// and next-segment make one pass over the allocated slots of the single-port slot
// memory. Hole search repeats that pass once per segment walked: up to TABLE_DEPTH
// passes. One request at a time; the result word sits in an output register.
// Reset (rst, synchronous): table empty, no slots allocated, no result.
module segment_directory_best_fit_hole_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [223:0] s_tdata,  // seg_key[31:0], seg_offset[95:32], seg_length[159:96], hole_min[223:160]
  input  logic [2:0]   s_tuser,  // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // offset_out[63:0], length_out[127:64]
  output logic [1:0]   m_tuser   // status
);

  sdbf_pkg::cmd_t cmd;
  sdbf_pkg::sts_t sts;

  sdbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdbf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (s_tuser),
    .in_key     (s_tdata[31:0]),
    .in_offset  (s_tdata[95:32]),
    .in_length  (s_tdata[159:96]),
    .in_min     (s_tdata[223:160]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_offset (m_tdata[63:0]),
    .out_length (m_tdata[127:64])
  );

endmodule
